@@ sv/urmt_pkg.sv @@
// shared types and codes for the unique range match table
package urmt_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned TAG_W = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_UNDET = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

@@ sv/urmt_req_if.sv @@
// request channel: one operation item
interface urmt_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [urmt_pkg::VAL_W-1:0]   range_low;
  logic signed [urmt_pkg::VAL_W-1:0]   range_high;
  logic [urmt_pkg::TAG_W-1:0]          entry_tag;
  logic signed [urmt_pkg::VAL_W-1:0]   point;

  modport source (output valid, func, range_low, range_high, entry_tag, point,
                  input ready);
  modport sink (input valid, func, range_low, range_high, entry_tag, point,
                output ready);
endinterface

@@ sv/urmt_rsp_if.sv @@
// response channel: one result item
interface urmt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [urmt_pkg::TAG_W-1:0] match_tag;

  modport source (output valid, status, match_tag, input ready);
  modport sink (input valid, status, match_tag, output ready);
endinterface

@@ sv/urmt_mem.sv @@
// single-port entry memory with registered read data
module urmt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic               clk,
  input  urmt_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      addr,
  input  urmt_pkg::entry_t   wdata,
  output urmt_pkg::entry_t   rdata
);

  urmt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ sv/urmt_ctrl.sv @@
// operation sequencer: fill count, query scan and result register
module urmt_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  urmt_req_if.sink           req,
  urmt_rsp_if.source         rsp,
  output urmt_pkg::mem_ctl_t mem_ctl,
  output logic [AW-1:0]      mem_addr,
  output urmt_pkg::entry_t   mem_wdata,
  input  urmt_pkg::entry_t   mem_rdata
);

  urmt_pkg::state_t                  state;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     rd_idx;
  logic                              rd_vld;
  logic [1:0]                        hits;
  logic [urmt_pkg::TAG_W-1:0]        found;
  logic signed [urmt_pkg::VAL_W-1:0] point;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic [urmt_pkg::TAG_W-1:0]        out_tag;

  logic                       accept;
  logic                       full;
  logic                       scanning;
  logic                       hit_now;
  logic [1:0]                 hits_next;
  logic [urmt_pkg::TAG_W-1:0] found_next;
  logic                       done;
  logic                       issue;

  assign req.ready = (state == urmt_pkg::S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign scanning  = (state == urmt_pkg::S_SCAN);

  assign hit_now    = rd_vld && (point >= mem_rdata.low) && (point <= mem_rdata.high);
  assign hits_next  = hits + {1'b0, hit_now};
  assign found_next = hit_now ? mem_rdata.tag : found;
  assign done       = (hits_next == 2'd2) || (rd_idx >= count);
  assign issue      = scanning && !done;

  assign mem_ctl.we = accept && (req.func == urmt_pkg::FUNC_ADD) && !full;
  assign mem_ctl.en = mem_ctl.we || issue;
  assign mem_addr   = scanning ? rd_idx[AW-1:0] : count[AW-1:0];
  assign mem_wdata  = '{low: req.range_low, high: req.range_high, tag: req.entry_tag};

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.match_tag = out_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= urmt_pkg::S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      hits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        urmt_pkg::S_IDLE: begin
          if (accept) begin
            out_tag <= '0;
            case (req.func)
              urmt_pkg::FUNC_CLEAR: begin
                count      <= '0;
                out_valid  <= 1'b1;
                out_status <= urmt_pkg::ST_DONE;
              end
              urmt_pkg::FUNC_ADD: begin
                out_valid  <= 1'b1;
                if (full) begin
                  out_status <= urmt_pkg::ST_FULL;
                end else begin
                  count      <= count + CW'(1);
                  out_status <= urmt_pkg::ST_DONE;
                end
              end
              urmt_pkg::FUNC_QUERY: begin
                state  <= urmt_pkg::S_SCAN;
                point  <= req.point;
                rd_idx <= '0;
                rd_vld <= 1'b0;
                hits   <= '0;
                found  <= '0;
              end
              default: begin
                out_valid  <= 1'b1;
                out_status <= urmt_pkg::ST_DONE;
              end
            endcase
          end
        end
        urmt_pkg::S_SCAN: begin
          hits   <= hits_next;
          found  <= found_next;
          rd_vld <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (done) begin
            state     <= urmt_pkg::S_IDLE;
            out_valid <= 1'b1;
            if (hits_next == 2'd1) begin
              out_status <= urmt_pkg::ST_MATCH;
              out_tag    <= found_next;
            end else begin
              out_status <= urmt_pkg::ST_UNDET;
              out_tag    <= '0;
            end
          end
        end
        default: begin
          state <= urmt_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/unique_range_match_table_top.sv @@
// unique range match table: top level with sequencer and entry memory
//
// req carries one operation item: func selects clear, add or query; add uses
// range_low, range_high and entry_tag, query uses point. rsp returns exactly
// one item per request with status and match_tag (nonzero only on a unique
// match). Bounds and points compare as signed values, bounds inclusive.
// Clear, add and the unused code answer in the cycle after acceptance.
// A query reads one stored entry per cycle from the single-port entry memory
// and answers once all N stored entries have been checked, or earlier when a
// second hit ends the scan.
// One item is in flight at a time; req.ready is low during a scan and while
// a finished result is held in the output register and rsp.ready is low.
// Reset empties the table (fill count to zero) and drops any held result;
// memory contents are not cleared and are never read above the fill count.
module unique_range_match_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  urmt_req_if.sink   req,
  urmt_rsp_if.source rsp
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  urmt_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_addr;
  urmt_pkg::entry_t   mem_wdata;
  urmt_pkg::entry_t   mem_rdata;

  urmt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  urmt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  a_write_only_on_add: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.we |-> (req.valid && req.ready && req.func == urmt_pkg::FUNC_ADD))
    else $error("entry write without an accepted add");

  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> (!rsp.valid || rsp.ready))
    else $error("item accepted while result register is blocked");

  a_quick_answer: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.func != urmt_pkg::FUNC_QUERY) |=> rsp.valid)
    else $error("non-query item did not answer in one cycle");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != urmt_pkg::ST_MATCH) |-> (rsp.match_tag == '0))
    else $error("nonzero tag without a unique match");

endmodule
